FILE: rtl/core/ssa_pkg.sv
package ssa_pkg;

   // config defaults and widths
   localparam int MAX_SET_SIZE_DEF = 1024;
   localparam int SET_SIZE_W       = 11;
   localparam int SUB_W            = 8;
   localparam int CHAN_W           = 3;
   localparam int ADC_W            = 8;
   localparam int ACC_W            = 16;
   localparam int IDX_W            = 10;
   localparam int ADDR_W           = 4;
   localparam int DATA_W           = 32;
   localparam int DIV_STEPS        = ACC_W;

   // multiplexer word: base | channel
   localparam logic [7:0] MUX_BASE = 8'h60;

   // command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // register indexes (paddr[3:2])
   typedef enum logic [1:0] {
      REG_SET_SIZE    = 2'd0,
      REG_SUB_SAMPLES = 2'd1,
      REG_CHANNEL     = 2'd2,
      REG_SPARE       = 2'd3
   } reg_idx_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;    // input word taken this cycle
      logic div_step;  // one quotient bit
      logic load_out;  // pending result into output register
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic group_end; // accepted word closes a group, needs a divide
      logic out_free;  // output register can take a word
   } ctrl_stat_type;

endpackage

FILE: rtl/core/ssa_ctrl.sv
module ssa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ssa_pkg::ctrl_stat_type stat,
   output ssa_pkg::ctrl_cmd_type  cmd
);
   import ssa_pkg::*;

   localparam int CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd.accept   = accept;
      cmd.div_step = 1'b0;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               state_in = stat.group_end ? ST_DIV : ST_EMIT;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

FILE: rtl/core/ssa_dpath.sv
module ssa_dpath #(
   parameter int MAX_SET_SIZE = ssa_pkg::MAX_SET_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ssa_pkg::ctrl_cmd_type             cmd,
   output ssa_pkg::ctrl_stat_type            stat,
   input  logic [ssa_pkg::SET_SIZE_W-1:0]    cfg_set_size,
   input  logic [ssa_pkg::SUB_W-1:0]         cfg_sub_samples,
   input  logic [ssa_pkg::CHAN_W-1:0]        cfg_channel,
   input  logic                              req_cmd,
   input  logic [ssa_pkg::ADC_W-1:0]         req_adc_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_start_accepted,
   output logic [7:0]                        rsp_mux_code,
   output logic                              rsp_sample_valid,
   output logic [7:0]                        rsp_sample_value,
   output logic [ssa_pkg::IDX_W-1:0]         rsp_sample_index,
   output logic                              rsp_trigger_conversion,
   output logic                              rsp_set_done
);
   import ssa_pkg::*;

   // largest set count the 11-bit register can ask for after the clamp
   localparam int SET_CAP = (MAX_SET_SIZE < 2047) ? MAX_SET_SIZE : 2047;
   localparam int SET_W   = $clog2(SET_CAP + 1);

   // set state
   logic                running_ff, running_in;
   logic [SET_W-1:0]    n_ff, n_in;
   logic [SUB_W-1:0]    g_ff, g_in;
   logic [SET_W-1:0]    idx_ff, idx_in;
   logic [SUB_W-1:0]    left_ff, left_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   // divider
   logic [ACC_W-1:0]    quo_ff, quo_in;
   logic [SUB_W-1:0]    rem_ff, rem_in;
   // pending result
   logic                p_start_ff, p_start_in;
   logic [7:0]          p_mux_ff, p_mux_in;
   logic                p_sv_ff, p_sv_in;
   logic [IDX_W-1:0]    p_idx_ff, p_idx_in;
   logic                p_trig_ff, p_trig_in;
   logic                p_done_ff, p_done_in;
   // output register
   logic                o_valid_ff, o_valid_in;
   logic                o_start_ff;
   logic [7:0]          o_mux_ff;
   logic                o_sv_ff;
   logic [7:0]          o_value_ff;
   logic [IDX_W-1:0]    o_idx_ff;
   logic                o_trig_ff;
   logic                o_done_ff;

   logic [SET_SIZE_W-1:0] n_clamp;
   logic [SUB_W-1:0]      g_start;
   logic [ACC_W-1:0]      acc_sum;
   logic                  set_end;
   logic [SET_W+IDX_W-1:0] idx_ext;
   logic [SUB_W:0]        shifted;
   logic [SUB_W+1:0]      diff;

   always_comb begin
      if (cfg_set_size == '0) begin
         n_clamp = SET_SIZE_W'(1);
      end else if ({6'b0, cfg_set_size} > 17'(MAX_SET_SIZE)) begin
         n_clamp = SET_SIZE_W'(MAX_SET_SIZE);
      end else begin
         n_clamp = cfg_set_size;
      end
   end

   assign g_start  = (cfg_sub_samples == '0) ? SUB_W'(1) : cfg_sub_samples;
   assign acc_sum  = acc_ff + ACC_W'(req_adc_value);
   assign idx_ext  = {{IDX_W{1'b0}}, idx_ff};

   assign stat.group_end = (req_cmd == CMD_TICK) && running_ff && (left_ff == SUB_W'(1));
   assign stat.out_free  = !o_valid_ff || rsp_ready;
   assign set_end        = stat.group_end && ((idx_ff + SET_W'(1)) == n_ff);

   // restoring divide step
   assign shifted = {rem_ff, quo_ff[ACC_W-1]};
   assign diff    = {1'b0, shifted} - {2'b0, g_ff};

   always_comb begin
      running_in = running_ff;
      n_in       = n_ff;
      g_in       = g_ff;
      idx_in     = idx_ff;
      left_in    = left_ff;
      acc_in     = acc_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      p_start_in = p_start_ff;
      p_mux_in   = p_mux_ff;
      p_sv_in    = p_sv_ff;
      p_idx_in   = p_idx_ff;
      p_trig_in  = p_trig_ff;
      p_done_in  = p_done_ff;

      if (cmd.accept) begin
         p_start_in = 1'b0;
         p_mux_in   = '0;
         p_sv_in    = 1'b0;
         p_idx_in   = '0;
         p_trig_in  = 1'b0;
         p_done_in  = 1'b0;
         quo_in     = '0;
         rem_in     = '0;
         if (req_cmd == CMD_START) begin
            if (!running_ff) begin
               running_in = 1'b1;
               n_in       = SET_W'(n_clamp);
               g_in       = g_start;
               idx_in     = '0;
               left_in    = g_start;
               acc_in     = '0;
               p_start_in = 1'b1;
               p_mux_in   = MUX_BASE | {5'b0, cfg_channel};
               p_trig_in  = 1'b1;
            end
         end else if (running_ff) begin
            p_trig_in = !set_end;
            if (stat.group_end) begin
               p_sv_in  = 1'b1;
               p_idx_in = idx_ext[IDX_W-1:0];
               idx_in   = idx_ff + SET_W'(1);
               left_in  = g_ff;
               acc_in   = '0;
               quo_in   = acc_sum;
            end else begin
               left_in = left_ff - SUB_W'(1);
               acc_in  = acc_sum;
            end
            if (set_end) begin
               running_in = 1'b0;
               p_done_in  = 1'b1;
            end
         end
      end else if (cmd.div_step) begin
         if (!diff[SUB_W+1]) begin
            rem_in = diff[SUB_W-1:0];
            quo_in = {quo_ff[ACC_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[SUB_W-1:0];
            quo_in = {quo_ff[ACC_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      o_valid_in = o_valid_ff;
      if (cmd.load_out) begin
         o_valid_in = 1'b1;
      end else if (rsp_ready) begin
         o_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         running_ff <= running_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      g_ff       <= g_in;
      idx_ff     <= idx_in;
      left_ff    <= left_in;
      acc_ff     <= acc_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      p_start_ff <= p_start_in;
      p_mux_ff   <= p_mux_in;
      p_sv_ff    <= p_sv_in;
      p_idx_ff   <= p_idx_in;
      p_trig_ff  <= p_trig_in;
      p_done_ff  <= p_done_in;
      if (cmd.load_out) begin
         o_start_ff <= p_start_ff;
         o_mux_ff   <= p_mux_ff;
         o_sv_ff    <= p_sv_ff;
         o_value_ff <= p_sv_ff ? quo_ff[7:0] : 8'd0;
         o_idx_ff   <= p_idx_ff;
         o_trig_ff  <= p_trig_ff;
         o_done_ff  <= p_done_ff;
      end
   end

   assign rsp_valid              = o_valid_ff;
   assign rsp_start_accepted     = o_start_ff;
   assign rsp_mux_code           = o_mux_ff;
   assign rsp_sample_valid       = o_sv_ff;
   assign rsp_sample_value       = o_value_ff;
   assign rsp_sample_index       = o_idx_ff;
   assign rsp_trigger_conversion = o_trig_ff;
   assign rsp_set_done           = o_done_ff;

endmodule

FILE: rtl/core/subsample_averaging_sampler.sv
// Path: a start word or a tick that does not close a group goes to the pending registers, then
//   to the output register once it is free; a tick that closes a group first runs the divide.
// Flow: a new word is taken only when idle, not while the 16-step restoring one-bit-a-cycle
//   divider runs or a pending word waits; it is taken while a result waits in the output reg.
// Reset (synchronous, active high): idle, no set running, output empty, registers back to
//   set_size 1, sub_samples 1, channel 0.
module subsample_averaging_sampler #(
   parameter int MAX_SET_SIZE = ssa_pkg::MAX_SET_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // input words
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [ssa_pkg::ADC_W-1:0]         req_adc_value,
   // result words
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_start_accepted,
   output logic [7:0]                        rsp_mux_code,
   output logic                              rsp_sample_valid,
   output logic [7:0]                        rsp_sample_value,
   output logic [ssa_pkg::IDX_W-1:0]         rsp_sample_index,
   output logic                              rsp_trigger_conversion,
   output logic                              rsp_set_done,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ssa_pkg::ADDR_W-1:0]        csr_paddr,
   input  logic [ssa_pkg::DATA_W-1:0]        csr_pwdata,
   output logic [ssa_pkg::DATA_W-1:0]        csr_prdata,
   output logic                              csr_pready
);
   import ssa_pkg::*;

   // config registers; set_size and sub_samples are latched on start, so a
   // write during a set only takes effect on the next one
   logic [SET_SIZE_W-1:0] set_size_ff, set_size_in;
   logic [SUB_W-1:0]      sub_ff, sub_in;
   logic [CHAN_W-1:0]     chan_ff, chan_in;
   logic                  wr_en;
   reg_idx_type           reg_idx;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = reg_idx_type'(csr_paddr[3:2]);

   always_comb begin
      set_size_in = set_size_ff;
      sub_in      = sub_ff;
      chan_in     = chan_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_SET_SIZE:    set_size_in = csr_pwdata[SET_SIZE_W-1:0];
            REG_SUB_SAMPLES: sub_in      = csr_pwdata[SUB_W-1:0];
            REG_CHANNEL:     chan_in     = csr_pwdata[CHAN_W-1:0];
            default: begin
               // unmapped: write dropped
            end
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         REG_SET_SIZE:    csr_prdata = DATA_W'(set_size_ff);
         REG_SUB_SAMPLES: csr_prdata = DATA_W'(sub_ff);
         REG_CHANNEL:     csr_prdata = DATA_W'(chan_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_size_ff <= SET_SIZE_W'(1);
         sub_ff      <= SUB_W'(1);
         chan_ff     <= '0;
      end else begin
         set_size_ff <= set_size_in;
         sub_ff      <= sub_in;
         chan_ff     <= chan_in;
      end
   end

   // sequencer: idle -> (divide) -> emit
   ssa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // set counters, accumulator, divider, pending and output words
   ssa_dpath #(
      .MAX_SET_SIZE (MAX_SET_SIZE)
   ) u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .stat                   (stat),
      .cfg_set_size           (set_size_ff),
      .cfg_sub_samples        (sub_ff),
      .cfg_channel            (chan_ff),
      .req_cmd                (req_cmd),
      .req_adc_value          (req_adc_value),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_start_accepted     (rsp_start_accepted),
      .rsp_mux_code           (rsp_mux_code),
      .rsp_sample_valid       (rsp_sample_valid),
      .rsp_sample_value       (rsp_sample_value),
      .rsp_sample_index       (rsp_sample_index),
      .rsp_trigger_conversion (rsp_trigger_conversion),
      .rsp_set_done           (rsp_set_done)
   );

endmodule

FILE: rtl/core/ssa_chk.sv
module ssa_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_start_accepted,
   input logic [7:0]                        rsp_mux_code,
   input logic                              rsp_sample_valid,
   input logic [7:0]                        rsp_sample_value,
   input logic [ssa_pkg::IDX_W-1:0]         rsp_sample_index,
   input logic                              rsp_trigger_conversion,
   input logic                              rsp_set_done
);

   // stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_value)
         && $stable(rsp_sample_index))
      else $error("result word changed while stalled");

   // start answer carries the mux base and asks for a conversion
   a_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_start_accepted |-> rsp_mux_code[7:3] == 5'b01100
         && rsp_trigger_conversion && !rsp_sample_valid && !rsp_set_done)
      else $error("bad start answer");

   // set end comes only with the last sample and stops conversions
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_set_done |-> rsp_sample_valid && !rsp_trigger_conversion)
      else $error("set end without last sample");

   // no sample: value and index cleared
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sample_valid |-> rsp_sample_value == 8'd0
         && rsp_sample_index == '0)
      else $error("stale sample fields");

endmodule

bind subsample_averaging_sampler ssa_chk u_ssa_chk (.*);
